// ===== sv/fletcher32_token_digest_unit_assert.svh =====
// Assertion macros for the token digest unit.
// Needs clk and arst_n in the scope of the including module.
`ifndef FLETCHER32_TOKEN_DIGEST_UNIT_ASSERT_SVH
`define FLETCHER32_TOKEN_DIGEST_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define F32TD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define F32TD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/f32td_pkg.sv =====
// Shared types and constants for the Fletcher-32 token digest unit.
// No dependencies.
package f32td_pkg;

	localparam logic [15:0] FLETCHER_MOD = 16'hFFFF;
	localparam logic [7:0]  SPACE_BYTE   = 8'h20;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_FINAL = 2'd1,
		OP_CLEAR = 2'd2
	} op_e;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       token_first;
		logic       insert_space;
	} req_t;

	typedef struct packed {
		logic [31:0] digest;
		logic        is_final;
		logic        byte_pending;
	} rsp_t;

	typedef struct packed {
		logic [15:0] sum_low;
		logic [15:0] sum_high;
		logic [7:0]  pending_byte;
		logic        pending_valid;
		logic        final_flag;
	} state_t;

endpackage

// ===== sv/f32td_core.sv =====
// Next-state and result logic for one request of the token digest.
// Depends on f32td_pkg.
module f32td_core (
	input  f32td_pkg::req_t   req,
	input  f32td_pkg::state_t cur,
	output f32td_pkg::state_t nxt,
	output f32td_pkg::rsp_t   rsp
);

	logic [15:0] word;
	logic [16:0] low_sum;
	logic [15:0] low_red;
	logic [16:0] high_sum;
	logic [15:0] high_red;
	logic        space_first;

	assign space_first = req.token_first & req.insert_space;

	always_comb begin
		word = '0;
		case (req.operation)
			f32td_pkg::OP_ADD: begin
				if (space_first && cur.pending_valid) begin
					word = {cur.pending_byte, f32td_pkg::SPACE_BYTE};
				end else if (space_first) begin
					word = {f32td_pkg::SPACE_BYTE, req.data_byte};
				end else begin
					word = {cur.pending_byte, req.data_byte};
				end
			end
			f32td_pkg::OP_FINAL: begin
				word = {cur.pending_byte, 8'h00};
			end
			default: begin
				word = '0;
			end
		endcase
	end

	// modular adds: both operands below 2^16, one conditional subtract suffices
	assign low_sum  = {1'b0, cur.sum_low} + {1'b0, word};
	assign low_red  = (low_sum >= {1'b0, f32td_pkg::FLETCHER_MOD}) ?
		16'(low_sum - {1'b0, f32td_pkg::FLETCHER_MOD}) : low_sum[15:0];
	assign high_sum = {1'b0, cur.sum_high} + {1'b0, low_red};
	assign high_red = (high_sum >= {1'b0, f32td_pkg::FLETCHER_MOD}) ?
		16'(high_sum - {1'b0, f32td_pkg::FLETCHER_MOD}) : high_sum[15:0];

	always_comb begin
		nxt = cur;
		case (req.operation)
			f32td_pkg::OP_ADD: begin
				if (space_first || cur.pending_valid) begin
					nxt.sum_low  = low_red;
					nxt.sum_high = high_red;
				end
				if (space_first && cur.pending_valid) begin
					nxt.pending_byte  = req.data_byte;
					nxt.pending_valid = 1'b1;
				end else if (space_first || cur.pending_valid) begin
					nxt.pending_byte  = '0;
					nxt.pending_valid = 1'b0;
				end else begin
					nxt.pending_byte  = req.data_byte;
					nxt.pending_valid = 1'b1;
				end
			end
			f32td_pkg::OP_FINAL: begin
				if (cur.pending_valid) begin
					nxt.sum_low       = low_red;
					nxt.sum_high      = high_red;
					nxt.pending_byte  = '0;
					nxt.pending_valid = 1'b0;
				end
				nxt.final_flag = 1'b1;
			end
			f32td_pkg::OP_CLEAR: begin
				nxt = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign rsp.digest       = {nxt.sum_high, nxt.sum_low};
	assign rsp.is_final     = nxt.final_flag;
	assign rsp.byte_pending = nxt.pending_valid;

endmodule

// ===== sv/fletcher32_token_digest_unit.sv =====
// Fletcher-32 digest over a stream of token bytes: request register, digest state,
// result register. Depends on f32td_pkg, f32td_core and the assert macro header.
//
// Usage:
//   Request channel item_valid/item_ready/item carries one byte, finalize or clear.
//   Result channel result_valid/result_ready/result returns the digest after
//   each request: sums, final flag and pending-byte flag.
//   Every request yields exactly one result, in order.
// Timing:
//   A request is registered on acceptance and its result is registered when the
//   request advances into the result register; result_valid rises with that load.
//   One request per cycle is sustained while results are taken; the digest
//   state updates on each advance, folding at most one 16-bit word.
// Reset:
//   arst_n clears the digest state and both pipeline valid bits.
// Stalls:
//   With result_ready low the result register holds; one more request can
//   wait in the request register, after which item_ready drops.
module fletcher32_token_digest_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  f32td_pkg::req_t  item,
	output logic             result_valid,
	input  logic             result_ready,
	output f32td_pkg::rsp_t  result
);

	`include "fletcher32_token_digest_unit_assert.svh"

	f32td_pkg::req_t   req_s1;
	logic              valid_s1;
	f32td_pkg::rsp_t   rsp_s2;
	logic              valid_s2;
	f32td_pkg::state_t state_q;
	f32td_pkg::state_t state_nxt;
	f32td_pkg::rsp_t   rsp_nxt;
	logic              advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	f32td_core u_core (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			req_s1 <= item;
		end
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = rsp_s2;

	`F32TD_ASSERT_ALWAYS(a_sums_reduced,
		state_q.sum_low != f32td_pkg::FLETCHER_MOD &&
		state_q.sum_high != f32td_pkg::FLETCHER_MOD,
		"digest sum not reduced")
	`F32TD_ASSERT_ALWAYS(a_pending_zero,
		state_q.pending_valid || state_q.pending_byte == 8'h00,
		"stale pending byte")
	`F32TD_ASSERT_NEXT(a_clear, advance && req_s1.operation == f32td_pkg::OP_CLEAR,
		state_q == '0 && result.digest == 32'h0, "clear did not reset digest")
	`F32TD_ASSERT_NEXT(a_final, advance && req_s1.operation == f32td_pkg::OP_FINAL,
		result.is_final && !result.byte_pending && result_valid, "finalize not reflected")

endmodule

// ===== test/f32td_digest_checker.sv =====
// Scoreboard for the Fletcher-32 token digest unit: predicts the digest after every
// accepted request and checks each returned result against it, in order.
// Depends on f32td_pkg.
module f32td_digest_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_ready,
	input  f32td_pkg::req_t item,
	input  logic            result_valid,
	input  logic            result_ready,
	input  f32td_pkg::rsp_t result,
	output int              mismatches,
	output int              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 100;

	logic [15:0]     acc_low;
	logic [15:0]     acc_high;
	logic [7:0]      held_byte;
	logic            held_valid;
	logic            finalized;
	f32td_pkg::rsp_t digests_due[$];
	f32td_pkg::rsp_t want;

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	function automatic void clear_digest();
		acc_low = '0;
		acc_high = '0;
		held_byte = '0;
		held_valid = 1'b0;
		finalized = 1'b0;
	endfunction

	function automatic void fold_word(logic [15:0] word);
		acc_low = 16'((int'(acc_low) + int'(word)) % int'(f32td_pkg::FLETCHER_MOD));
		acc_high = 16'((int'(acc_high) + int'(acc_low)) % int'(f32td_pkg::FLETCHER_MOD));
	endfunction

	function automatic void take_byte(logic [7:0] b);
		if (held_valid) begin
			fold_word({held_byte, b});
			held_byte = '0;
			held_valid = 1'b0;
		end else begin
			held_byte = b;
			held_valid = 1'b1;
		end
	endfunction

	function automatic f32td_pkg::rsp_t apply_request(f32td_pkg::req_t r);
		f32td_pkg::rsp_t o;
		case (r.operation)
			f32td_pkg::OP_ADD: begin
				if (r.token_first && r.insert_space) begin
					take_byte(f32td_pkg::SPACE_BYTE);
				end
				take_byte(r.data_byte);
			end
			f32td_pkg::OP_FINAL: begin
				if (held_valid) begin
					fold_word({held_byte, 8'h00});
					held_byte = '0;
					held_valid = 1'b0;
				end
				finalized = 1'b1;
			end
			f32td_pkg::OP_CLEAR: begin
				clear_digest();
			end
			default: ;
		endcase
		o.digest = {acc_high, acc_low};
		o.is_final = finalized;
		o.byte_pending = held_valid;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_digest();
			digests_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (digests_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no request waiting", result));
				end else begin
					want = digests_due.pop_front();
					if (result.digest !== want.digest) begin
						report_mismatch($sformatf("digest %h, want %h",
							result.digest, want.digest));
					end
					if (result.is_final !== want.is_final) begin
						report_mismatch($sformatf("is_final %b, want %b",
							result.is_final, want.is_final));
					end
					if (result.byte_pending !== want.byte_pending) begin
						report_mismatch($sformatf("byte_pending %b, want %b",
							result.byte_pending, want.byte_pending));
					end
				end
			end
			if (item_valid && item_ready) begin
				digests_due.push_back(apply_request(item));
			end
			outstanding <= digests_due.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Top of the token digest unit testbench: clock, reset, request and result traffic,
// watchdog and verdict. Depends on f32td_pkg, the unit and f32td_digest_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 11;
	localparam int ITEMS_PER_PHASE = 530;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	f32td_pkg::req_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	f32td_pkg::rsp_t result;

	int send_idle = 23;
	int recv_idle = 78;
	int requests_sent = 0;
	int stall_cycles = 0;
	int mismatches;
	int outstanding;

	always #4 clk = ~clk;

	fletcher32_token_digest_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	f32td_digest_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic f32td_pkg::req_t make_req(logic [1:0] op, logic [7:0] data,
			logic first, logic space);
		f32td_pkg::req_t r;
		r.operation = op;
		r.data_byte = data;
		r.token_first = first;
		r.insert_space = space;
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return f32td_pkg::SPACE_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send(f32td_pkg::req_t r);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= r;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		requests_sent++;
	endtask

	task automatic send_token();
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		send(make_req(f32td_pkg::OP_ADD, pick_byte(), 1'b1, 1'($urandom_range(1))));
		for (int k = 1; k < len; k++) begin
			send(make_req(f32td_pkg::OP_ADD, pick_byte(), 1'b0, 1'($urandom_range(1))));
		end
	endtask

	task automatic run_phase(int count);
		int pick;
		int stop;
		stop = requests_sent + count;
		while (requests_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_token();
			end else if (pick < 88) begin
				send(make_req(f32td_pkg::OP_FINAL, pick_byte(), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			end else if (pick < 92) begin
				send(make_req(f32td_pkg::OP_CLEAR, pick_byte(), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			end else if (pick < 95) begin
				send(make_req(OP_UNUSED, pick_byte(), 1'($urandom_range(1)),
					1'($urandom_range(1))));
			end else begin
				send(f32td_pkg::req_t'(12'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		send(make_req(f32td_pkg::OP_ADD, 8'h00, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_ADD, 8'hFF, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_ADD, 8'hFF, 1'b1, 1'b1));
		send(make_req(f32td_pkg::OP_ADD, 8'h41, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_ADD, 8'h42, 1'b1, 1'b1));
		send(make_req(f32td_pkg::OP_ADD, 8'h7E, 1'b0, 1'b1));
		send(make_req(f32td_pkg::OP_ADD, 8'h80, 1'b1, 1'b0));
		send(make_req(f32td_pkg::OP_FINAL, 8'h00, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_FINAL, 8'hFF, 1'b1, 1'b1));
		send(make_req(f32td_pkg::OP_ADD, 8'h55, 1'b0, 1'b0));
		send(make_req(OP_UNUSED, 8'hFF, 1'b1, 1'b1));
		send(make_req(f32td_pkg::OP_ADD, 8'hAA, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1));
		// sums wrap around the modulus
		for (int k = 0; k < 5; k++) begin
			send(make_req(f32td_pkg::OP_ADD, 8'hFF, 1'b0, 1'b0));
			send(make_req(f32td_pkg::OP_ADD, 8'hFE, 1'b0, 1'b0));
		end
		send(make_req(f32td_pkg::OP_FINAL, 8'h00, 1'b0, 1'b0));
		send(make_req(f32td_pkg::OP_ADD, f32td_pkg::SPACE_BYTE, 1'b1, 1'b1));
		send(make_req(f32td_pkg::OP_CLEAR, 8'h00, 1'b0, 1'b0));

		run_phase(ITEMS_PER_PHASE);
		send_idle = 78;
		recv_idle = 23;
		run_phase(ITEMS_PER_PHASE);
		send_idle = 0;
		recv_idle = 0;
		run_phase(ITEMS_PER_PHASE);
		item_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/f32td_pkg.sv
sv/f32td_core.sv
sv/fletcher32_token_digest_unit.sv
test/f32td_digest_checker.sv
test/tb.sv
